FILE: rtl/core/mbsp_pkg.sv
package mbsp_pkg;

    // Status byte boundaries and the system-exclusive framing bytes.
    localparam logic [7:0] STATUS_MIN   = 8'h80;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_STOP   = 8'hF7;
    localparam logic [7:0] REALTIME_MIN = 8'hF8;

    // Result kinds, carried on the master-side tuser.
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    // Depth of the result queue and its index width.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [1:0] msg_len;
        logic       sysex_end;
    } t_result;

    // Parser state; the third pending byte is never stored because the
    // message is complete as soon as it arrives.
    typedef struct packed {
        logic       in_sysex;
        logic [1:0] pend_cnt;
        logic [7:0] pend0;
        logic [7:0] pend1;
    } t_state;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
        t_state     next;
    } t_dec;

    // Message length in bytes for a status byte.
    function automatic logic [1:0] status_len(input logic [7:0] s);
        logic [1:0] len;
        if (s < 8'hC0) begin
            len = 2'd3;
        end else if (s < 8'hE0) begin
            len = 2'd2;
        end else if (s < 8'hF0) begin
            len = 2'd3;
        end else if (s == 8'hF1 || s == 8'hF3) begin
            len = 2'd2;
        end else if (s == 8'hF2) begin
            len = 2'd3;
        end else begin
            len = 2'd1;
        end
        return len;
    endfunction

    function automatic t_result make_result(input logic kind, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] c,
                                            input logic [1:0] len, input logic last);
        t_result r;
        r.kind      = kind;
        r.byte_a    = a;
        r.byte_b    = b;
        r.byte_c    = c;
        r.msg_len   = len;
        r.sysex_end = last;
        return r;
    endfunction

endpackage

FILE: rtl/core/mbsp_decode.sv
module mbsp_decode (
    input  logic [7:0]      i_byte,
    input  mbsp_pkg::t_state i_state,
    output mbsp_pkg::t_dec  o_dec
);

    always_comb begin
        mbsp_pkg::t_dec  d;
        mbsp_pkg::t_result close_r;
        d        = '0;
        d.next   = i_state;
        close_r  = mbsp_pkg::make_result(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_STOP,
                                         8'd0, 8'd0, 2'd1, 1'b1);
        if (i_state.in_sysex) begin
            if (i_byte < mbsp_pkg::STATUS_MIN) begin
                d.num  = 2'd1;
                d.res0 = mbsp_pkg::make_result(mbsp_pkg::KIND_SYSEX, i_byte,
                                               8'd0, 8'd0, 2'd1, 1'b0);
            end else if (i_byte == mbsp_pkg::SYSEX_STOP) begin
                d.num           = 2'd1;
                d.res0          = close_r;
                d.next.in_sysex = 1'b0;
            end else if (i_byte == mbsp_pkg::SYSEX_START) begin
                // A new run closes the old one first.
                d.num  = 2'd2;
                d.res0 = close_r;
                d.res1 = mbsp_pkg::make_result(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_START,
                                               8'd0, 8'd0, 2'd1, 1'b0);
            end else if (i_byte > mbsp_pkg::SYSEX_START) begin
                d.num  = 2'd1;
                d.res0 = mbsp_pkg::make_result(mbsp_pkg::KIND_SHORT, i_byte,
                                               8'd0, 8'd0, 2'd1, 1'b0);
            end else begin
                // Channel status aborts the run and opens a message of two or
                // three bytes, so nothing else is emitted yet.
                d.num           = 2'd1;
                d.res0          = close_r;
                d.next.in_sysex = 1'b0;
                d.next.pend_cnt = 2'd1;
                d.next.pend0    = i_byte;
                d.next.pend1    = 8'd0;
            end
        end else begin
            if (i_byte == mbsp_pkg::SYSEX_START) begin
                d.num           = 2'd1;
                d.res0          = mbsp_pkg::make_result(mbsp_pkg::KIND_SYSEX,
                                                        mbsp_pkg::SYSEX_START,
                                                        8'd0, 8'd0, 2'd1, 1'b0);
                d.next.in_sysex = 1'b1;
                d.next.pend_cnt = 2'd0;
            end else if (i_byte >= mbsp_pkg::REALTIME_MIN) begin
                d.num  = 2'd1;
                d.res0 = mbsp_pkg::make_result(mbsp_pkg::KIND_SHORT, i_byte,
                                               8'd0, 8'd0, 2'd1, 1'b0);
            end else if (i_byte >= mbsp_pkg::STATUS_MIN) begin
                d.next.pend0 = i_byte;
                d.next.pend1 = 8'd0;
                if (mbsp_pkg::status_len(i_byte) == 2'd1) begin
                    d.num           = 2'd1;
                    d.res0          = mbsp_pkg::make_result(mbsp_pkg::KIND_SHORT, i_byte,
                                                            8'd0, 8'd0, 2'd1, 1'b0);
                    d.next.pend_cnt = 2'd0;
                end else begin
                    d.next.pend_cnt = 2'd1;
                end
            end else begin
                case (i_state.pend_cnt)
                    2'd1: begin
                        if (mbsp_pkg::status_len(i_state.pend0) == 2'd2) begin
                            d.num           = 2'd1;
                            d.res0          = mbsp_pkg::make_result(mbsp_pkg::KIND_SHORT,
                                                                    i_state.pend0, i_byte,
                                                                    8'd0, 2'd2, 1'b0);
                            d.next.pend_cnt = 2'd0;
                        end else begin
                            d.next.pend1    = i_byte;
                            d.next.pend_cnt = 2'd2;
                        end
                    end
                    2'd2: begin
                        d.num           = 2'd1;
                        d.res0          = mbsp_pkg::make_result(mbsp_pkg::KIND_SHORT,
                                                                i_state.pend0, i_state.pend1,
                                                                i_byte, 2'd3, 1'b0);
                        d.next.pend_cnt = 2'd0;
                    end
                    default: begin
                        // Data byte with no status pending is dropped.
                        d.num = 2'd0;
                    end
                endcase
            end
        end
        o_dec = d;
    end

endmodule

FILE: rtl/core/midi_byte_stream_parser_top.sv
// MIDI byte stream parser. Each input beat carries one raw MIDI byte; the block
// assembles channel and system common messages of one to three bytes (lengths
// from the standard status table) and emits each one as a single output beat
// once it is complete, with tuser low. System-exclusive data from F0 onward is
// passed out one byte per beat with tuser high, and the run is closed by an F7
// beat with tlast high; the block inserts that F7 itself when a new F0 or a
// channel status byte cuts the run short. Realtime and other system bytes seen
// inside a run come out at once as one-byte messages, in stream order. Data
// bytes with no pending status are dropped, and running status is not
// supported. Timing: a byte is decoded in the cycle it is accepted and its
// results are registered into the result queue. The input takes one byte
// per cycle while s_axis_tready is high; a byte yields zero, one or (only for
// F0 inside a run) two output beats, and the output side delivers one beat per
// cycle while m_axis_tready is high, from a four-entry result queue. Input
// ready is low while that queue has fewer than two free entries, so the block
// takes one byte per cycle while the output takes every beat and no F0 cuts runs.
module midi_byte_stream_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] byte_a, [15:8] byte_b, [23:16] byte_c,
                                        // [25:24] msg_len, [31:26] zero
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // sysex_end
);

    localparam int unsigned CntW = mbsp_pkg::QUEUE_AW + 1;

    mbsp_pkg::t_state  r_state;
    mbsp_pkg::t_dec    dec;
    mbsp_pkg::t_result r_queue [mbsp_pkg::QUEUE_DEPTH];
    mbsp_pkg::t_result head;

    logic [mbsp_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [mbsp_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]               r_count, n_count;
    logic                          accept;
    logic                          pop;
    logic [1:0]                    push;

    // The decoder works straight off the accepted byte and the parser state;
    // its results land in the queue registers at the same edge.
    mbsp_decode u_decode (
        .i_byte  (s_axis_tdata),
        .i_state (r_state),
        .o_dec   (dec)
    );

    // Room for the worst case of two results per byte.
    assign s_axis_tready = (r_count <= CntW'(mbsp_pkg::QUEUE_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept ? dec.num : 2'd0;

    assign m_axis_tvalid = (r_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign head          = r_queue[r_rd_ptr];

    assign m_axis_tdata  = {6'd0, head.msg_len, head.byte_c, head.byte_b, head.byte_a};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.sysex_end;

    always_comb begin
        n_wr_ptr = r_wr_ptr + mbsp_pkg::QUEUE_AW'(push);
        n_rd_ptr = r_rd_ptr + mbsp_pkg::QUEUE_AW'(pop);
        n_count  = r_count + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_state <= dec.next;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue payload needs no reset; entries are only read once written.
    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_queue[r_wr_ptr] <= dec.res0;
        end
        if (push == 2'd2) begin
            r_queue[r_wr_ptr + mbsp_pkg::QUEUE_AW'(1)] <= dec.res1;
        end
    end

endmodule

FILE: rtl/core/mbsp_checker.sv
module mbsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // The queue is empty right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // A stalled beat holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // The end of a run is always a system-exclusive F7 beat.
    a_end_is_f7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tuser && m_axis_tdata[7:0] == mbsp_pkg::SYSEX_STOP)
        else $error("run end flag on a beat that is not a sysex F7");

    // System-exclusive beats carry one byte only.
    a_sysex_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:8] == 24'h010000)
        else $error("sysex beat with extra bytes or wrong length");

    // Short messages start with a status byte and have a nonzero length.
    a_short_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[7] && m_axis_tdata[25:24] != 2'd0 && !m_axis_tlast)
        else $error("malformed short message beat");

endmodule

bind midi_byte_stream_parser_top mbsp_checker u_mbsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/midi_result_checker.sv
module midi_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream going into the parser.
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    // Message stream coming out of the parser.
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_user,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_message_count,
    output int          o_sysex_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Parser state as this checker sees it.
    logic       in_run;
    logic [1:0] held_cnt;
    logic [7:0] held [0:2];

    mbsp_pkg::t_result expected_messages [$];
    mbsp_pkg::t_result want;
    int      fails = 0;
    int      messages = 0;
    int      sysex_beats = 0;

    initial begin
        o_fail_count    = 0;
        o_outstanding   = 0;
        o_message_count = 0;
        o_sysex_count   = 0;
    end

    function automatic logic [1:0] bytes_in_message(input logic [7:0] status);
        logic [1:0] n;
        case (status[7:4])
            4'hC, 4'hD: n = 2'd2;
            4'hF: begin
                if (status == 8'hF1 || status == 8'hF3) begin
                    n = 2'd2;
                end else if (status == 8'hF2) begin
                    n = 2'd3;
                end else begin
                    n = 2'd1;
                end
            end
            default: n = 2'd3;
        endcase
        return n;
    endfunction

    task automatic push_message(input logic kind, input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c, input logic [1:0] len,
                                input logic last);
        mbsp_pkg::t_result r;
        r.kind      = kind;
        r.byte_a    = a;
        r.byte_b    = b;
        r.byte_c    = c;
        r.msg_len   = len;
        r.sysex_end = last;
        expected_messages.insert(expected_messages.size(), r);
    endtask

    // Works out what one incoming byte produces and updates the state.
    task automatic decode_byte(input logic [7:0] b);
        logic [1:0] need;
        if (in_run) begin
            if (b < mbsp_pkg::STATUS_MIN) begin
                push_message(mbsp_pkg::KIND_SYSEX, b, 8'h00, 8'h00, 2'd1, 1'b0);
                return;
            end
            if (b == mbsp_pkg::SYSEX_STOP) begin
                push_message(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_STOP, 8'h00, 8'h00,
                             2'd1, 1'b1);
                in_run = 1'b0;
                return;
            end
            if (b == mbsp_pkg::SYSEX_START) begin
                // A new run closes the old one first.
                push_message(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_STOP, 8'h00, 8'h00,
                             2'd1, 1'b1);
                push_message(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_START, 8'h00, 8'h00,
                             2'd1, 1'b0);
                return;
            end
            if (b > mbsp_pkg::SYSEX_START) begin
                push_message(mbsp_pkg::KIND_SHORT, b, 8'h00, 8'h00, 2'd1, 1'b0);
                return;
            end
            // A channel status byte ends the run and is then parsed normally.
            push_message(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_STOP, 8'h00, 8'h00,
                         2'd1, 1'b1);
            in_run = 1'b0;
        end

        if (b == mbsp_pkg::SYSEX_START) begin
            held_cnt = 2'd0;
            in_run   = 1'b1;
            push_message(mbsp_pkg::KIND_SYSEX, mbsp_pkg::SYSEX_START, 8'h00, 8'h00,
                         2'd1, 1'b0);
            return;
        end
        if (b >= mbsp_pkg::REALTIME_MIN) begin
            push_message(mbsp_pkg::KIND_SHORT, b, 8'h00, 8'h00, 2'd1, 1'b0);
            return;
        end

        if (b >= mbsp_pkg::STATUS_MIN) begin
            held[0]  = b;
            held[1]  = 8'h00;
            held[2]  = 8'h00;
            held_cnt = 2'd1;
        end else begin
            // Data with no status waiting is thrown away.
            if (held_cnt == 2'd0 || held_cnt > 2'd2) begin
                return;
            end
            held[held_cnt] = b;
            held_cnt       = held_cnt + 2'd1;
        end

        need = bytes_in_message(held[0]);
        if (held_cnt >= need) begin
            push_message(mbsp_pkg::KIND_SHORT, held[0],
                         (held_cnt > 2'd1) ? held[1] : 8'h00,
                         (held_cnt > 2'd2) ? held[2] : 8'h00,
                         held_cnt, 1'b0);
            held_cnt = 2'd0;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            fails++;
            $error("%s: expected %02h, actual %02h", name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_run   = 1'b0;
            held_cnt = 2'd0;
            held[0]  = 8'h00;
            held[1]  = 8'h00;
            held[2]  = 8'h00;
            expected_messages.delete();
        end else begin
            // Output first: a beat leaving now never comes from a byte entering now.
            if (i_out_valid && i_out_ready) begin
                messages++;
                if (i_out_user === mbsp_pkg::KIND_SYSEX) begin
                    sysex_beats++;
                end
                if (expected_messages.size() == 0) begin
                    fails++;
                    $error("message beat %08h with nothing expected", i_out_data);
                end else begin
                    want = expected_messages.pop_front();
                    check_field("kind", {7'd0, want.kind}, {7'd0, i_out_user});
                    check_field("byte_a", want.byte_a, i_out_data[7:0]);
                    check_field("byte_b", want.byte_b, i_out_data[15:8]);
                    check_field("byte_c", want.byte_c, i_out_data[23:16]);
                    check_field("msg_len", {6'd0, want.msg_len}, {6'd0, i_out_data[25:24]});
                    check_field("sysex_end", {7'd0, want.sysex_end}, {7'd0, i_out_last});
                    check_field("tdata_pad", 8'h00, {2'd0, i_out_data[31:26]});
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data);
            end
        end
        o_fail_count    <= fails;
        o_outstanding   <= expected_messages.size();
        o_message_count <= messages;
        o_sysex_count   <= sysex_beats;
    end

endmodule

FILE: bench/midi_byte_stream_parser_top_test.sv
// Byte-level test of the MIDI stream parser. A short directed sequence walks
// through the special cases (stray data, realtime bytes inside a partial
// message, status bytes cutting a message short, system common messages,
// system-exclusive runs closed by F7, by a new F0 and by a channel status),
// then random traffic follows. Most of the random traffic is well-formed
// messages and sysex runs with random content; the rest is truncated
// messages and raw noise bytes. The checker beside the block predicts every
// output beat and compares it field by field; this module only drives the
// two streams and reports the verdict.
module midi_byte_stream_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1900;
    localparam int TAIL_CYCLES  = 8;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int outstanding;
    int message_count;
    int sysex_count;

    // Bytes sent so far, and whether both sides currently run without gaps.
    int   bytes_sent = 0;
    logic no_idle    = 1'b0;

    logic [7:0] directed_bytes [0:28];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    midi_byte_stream_parser_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    midi_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .i_out_user      (m_axis_tuser),
        .i_out_last      (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_message_count (message_count),
        .o_sysex_count   (sysex_count)
    );

    // Sends one byte as one input beat. The gap before it is drawn per beat;
    // every 128 beats the run decides whether the next stretch has no gaps
    // at all. When the gap is zero, tvalid simply stays high for the new beat.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (bytes_sent % 128 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
        end
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] random_data();
        return 8'($urandom_range(0, 127));
    endfunction

    // A realtime byte or other system byte that may appear inside a sysex
    // run without ending it.
    function automatic logic [7:0] random_interloper();
        logic [7:0] b;
        b = 8'($urandom_range(8'hF1, 8'hFF));
        if (b == mbsp_pkg::SYSEX_STOP) begin
            b = mbsp_pkg::REALTIME_MIN;
        end
        return b;
    endfunction

    // One channel message, sometimes cut short or with a realtime byte
    // slipped in between its bytes.
    task automatic send_channel_message();
        logic [7:0] status;
        int         data_bytes;
        status     = 8'($urandom_range(8'h80, 8'hEF));
        data_bytes = (status[7:5] == 3'b110) ? 1 : 2;
        if ($urandom_range(0, 9) == 0) begin
            data_bytes--;
        end
        send_byte(status);
        for (int i = 0; i < data_bytes; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_byte(8'($urandom_range(mbsp_pkg::REALTIME_MIN, 8'hFF)));
            end
            send_byte(random_data());
        end
    endtask

    task automatic send_system_common();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0: begin
                send_byte(8'hF1);
                send_byte(random_data());
            end
            1: begin
                send_byte(8'hF2);
                send_byte(random_data());
                send_byte(random_data());
            end
            2: begin
                send_byte(8'hF3);
                send_byte(random_data());
            end
            default: send_byte(8'($urandom_range(8'hF4, 8'hF6)));
        endcase
    endtask

    // One sysex run with random payload. Most runs end in F7; the others are
    // cut short by a new F0 or by a channel status byte.
    task automatic send_sysex_run();
        int payload;
        int ending;
        payload = $urandom_range(0, 12);
        send_byte(mbsp_pkg::SYSEX_START);
        for (int i = 0; i < payload; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_byte(random_interloper());
            end
            send_byte(random_data());
        end
        ending = $urandom_range(0, 19);
        if (ending < 14) begin
            send_byte(mbsp_pkg::SYSEX_STOP);
        end else if (ending < 17) begin
            send_byte(mbsp_pkg::SYSEX_START);
        end else begin
            send_byte(8'($urandom_range(8'h80, 8'hEF)));
        end
    endtask

    // Output side: a stall of random length is drawn before every beat, except
    // during the gap-free stretches chosen by the sender.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int pick;

        // Directed part: stray data, the extremes of the byte, every message
        // length, realtime inside a partial message, a status byte cutting a
        // message short, a stray F7, and a sysex run that sees a realtime
        // byte, a system common byte, a second F0 and a channel status.
        directed_bytes = '{
            8'h00,
            8'h90, 8'h3C, 8'h7F,
            8'hC5, 8'h7F,
            8'hF2, 8'h01, 8'h02,
            8'h80, 8'h01, 8'hFE, 8'h02,
            8'hE0, 8'h7F, 8'hA0, 8'h11, 8'hF6,
            mbsp_pkg::SYSEX_STOP,
            mbsp_pkg::SYSEX_START, 8'h7F, 8'hF8, 8'hF1, mbsp_pkg::SYSEX_START, 8'hDF, 8'h33,
            mbsp_pkg::SYSEX_START, mbsp_pkg::SYSEX_STOP,
            8'hFF
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i]);
        end

        while (bytes_sent < RANDOM_BYTES + 29) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_channel_message();
            end else if (pick < 50) begin
                send_system_common();
            end else if (pick < 58) begin
                send_byte(8'($urandom_range(mbsp_pkg::REALTIME_MIN, 8'hFF)));
            end else if (pick < 84) begin
                send_sysex_run();
            end else if (pick < 90) begin
                send_byte(random_data());
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        s_axis_tvalid <= 1'b0;

        // The checker's counters are registered and trail the beats they count, so step
        // the clock before polling, then let the expected queue drain and wait out the tail.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Drove %0d MIDI bytes; %0d message beats checked, %0d of them sysex bytes.",
                 bytes_sent, message_count, sysex_count);
        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with every gap and stall
    // at its longest.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: midi_byte_stream_parser_top.f
rtl/core/mbsp_pkg.sv
rtl/core/mbsp_decode.sv
rtl/core/midi_byte_stream_parser_top.sv
rtl/core/mbsp_checker.sv
bench/midi_result_checker.sv
bench/midi_byte_stream_parser_top_test.sv
